[rtl/core/ramu_pkg.sv]
// Package for the rational add/multiply unit.
// Holds the port width, command codes, sequencer state type, the shared unit opcode and the request struct.
package ramu_pkg;

   // Fixed port width of every numerator and denominator field
   localparam int unsigned PORT_W = 64;

   // Command codes on req_command
   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_MUL = 1'b1;

   // Shared arithmetic unit operations
   typedef enum logic {
      ALU_DIV = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   // Request from the sequencer to the shared unit
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD,
      ST_A_Q1,
      ST_A_RD,
      ST_A_S1,
      ST_A_X,
      ST_A_S2,
      ST_A_Y,
      ST_A_SUM,
      ST_M_N,
      ST_M_D,
      ST_R_NUM,
      ST_R_DEN,
      ST_DONE
   } state_type;

endpackage

[rtl/core/ramu_alu.sv]
// Shared bit-serial unit: restoring divide (quotient and remainder) or
// shift-add multiply wrapped to WIDTH bits. Depends on ramu_pkg.
module ramu_alu #(
   parameter int unsigned WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ramu_pkg::alu_req_type req,
   input  logic [WIDTH-1:0]     opa,
   input  logic [WIDTH-1:0]     opb,
   output logic                 done,
   output logic [WIDTH-1:0]     result,
   output logic [WIDTH-1:0]     remainder
);

   localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   ramu_pkg::alu_op_type op_ff, op_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [WIDTH-1:0]    acc_ff, acc_in;   // remainder or product
   logic [WIDTH-1:0]    sh_ff, sh_in;     // quotient or multiplier bits
   logic [WIDTH-1:0]    b_ff, b_in;       // divisor or shifted multiplicand
   logic [WIDTH:0]      trial;
   logic                ge;

   // One step of either operation per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      trial   = {acc_ff, sh_ff[WIDTH-1]};
      ge      = (trial >= {1'b0, b_ff});
      if (!busy_ff && req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         acc_in  = '0;
         sh_in   = (req.op == ramu_pkg::ALU_DIV) ? opa : opb;
         b_in    = (req.op == ramu_pkg::ALU_DIV) ? opb : opa;
      end else if (busy_ff) begin
         case (op_ff)
            ramu_pkg::ALU_DIV: begin
               acc_in = ge ? WIDTH'(trial - {1'b0, b_ff}) : trial[WIDTH-1:0];
               sh_in  = {sh_ff[WIDTH-2:0], ge};
            end
            ramu_pkg::ALU_MUL: begin
               if (sh_ff[0]) acc_in = acc_ff + b_ff;
               b_in  = {b_ff[WIDTH-2:0], 1'b0};
               sh_in = {1'b0, sh_ff[WIDTH-1:1]};
            end
            default: ;
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
   end

   // Division by zero yields zero
   assign done      = done_ff;
   assign result    = (op_ff == ramu_pkg::ALU_MUL) ? acc_ff :
                      ((b_ff == '0) ? '0 : sh_ff);
   assign remainder = acc_ff;

endmodule

[rtl/core/rational_add_multiply_unit.sv]
// Top level of the gcd-reduced rational add/multiply unit.
// Depends on ramu_pkg and ramu_alu.
//
// Usage:
//   req_* carries one item: a command (add or multiply) and two
//   sign-magnitude rationals. It is accepted at a clock edge with
//   req_valid high and req_stall low. rsp_* returns one reduced rational
//   per item, taken at an edge with rsp_valid high and rsp_stall low.
//   Numerators and denominators use their low WIDTH bits; results are
//   zero-extended to 64 bits and wrap modulo 2^WIDTH.
//   Every divide or multiply runs on one shared bit-serial unit, which
//   takes the operands, works through them bit by bit and hands back the
//   result. Multiply runs 2 products, the reduction gcd and 2 divides;
//   add runs the denominator gcd, 3 divides and 3 products before the
//   same reduction. Each gcd costs one divide per Euclid step (at most
//   about 93 steps at 64 bits).
//   Only one item is in flight: req_stall is high from acceptance until
//   the result has been taken. While rsp_stall is high the result holds.
//   Reset (synchronous) returns the block to idle and drops any item.
module rational_add_multiply_unit #(
   parameter int unsigned WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_a_num,
   input  logic [63:0] req_a_den,
   input  logic        req_a_neg,
   input  logic [63:0] req_b_num,
   input  logic [63:0] req_b_den,
   input  logic        req_b_neg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_res_num,
   output logic [63:0] rsp_res_den,
   output logic        rsp_res_neg
);

   ramu_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic                pend_ff, pend_in;
   logic [WIDTH-1:0]    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic                ang_ff, ang_in, bng_ff, bng_in, neg_ff, neg_in;
   logic [WIDTH-1:0]    gx_ff, gx_in, gy_ff, gy_in;
   logic [WIDTH-1:0]    q_ff, q_in, xv_ff, xv_in, yv_ff, yv_in;
   logic [WIDTH-1:0]    rn_ff, rn_in, rd_ff, rd_in;

   ramu_pkg::alu_req_type alu_req;
   logic [WIDTH-1:0]      alu_a, alu_b, alu_res, alu_rem;
   logic                  alu_done;

   ramu_alu #(.WIDTH(WIDTH)) u_alu (
      .clock     (clock),
      .reset     (reset),
      .req       (alu_req),
      .opa       (alu_a),
      .opb       (alu_b),
      .done      (alu_done),
      .result    (alu_res),
      .remainder (alu_rem)
   );

   // Sequencer: next state, operand select and datapath updates
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      pend_in  = pend_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ang_in = ang_ff; bng_in = bng_ff; neg_in = neg_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      q_in = q_ff; xv_in = xv_ff; yv_in = yv_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      alu_req.start = 1'b0;
      alu_req.op    = ramu_pkg::ALU_DIV;
      alu_a = '0;
      alu_b = '0;

      // Operands of the operation a state runs
      case (state_ff)
         ramu_pkg::ST_GCD:   begin alu_a = gx_ff; alu_b = gy_ff; end
         ramu_pkg::ST_A_Q1:  begin alu_a = ad_ff; alu_b = gx_ff; end
         ramu_pkg::ST_A_RD:  begin
            alu_req.op = ramu_pkg::ALU_MUL; alu_a = q_ff; alu_b = bd_ff;
         end
         ramu_pkg::ST_A_S1:  begin alu_a = rd_ff; alu_b = ad_ff; end
         ramu_pkg::ST_A_X:   begin
            alu_req.op = ramu_pkg::ALU_MUL; alu_a = q_ff; alu_b = an_ff;
         end
         ramu_pkg::ST_A_S2:  begin alu_a = rd_ff; alu_b = bd_ff; end
         ramu_pkg::ST_A_Y:   begin
            alu_req.op = ramu_pkg::ALU_MUL; alu_a = q_ff; alu_b = bn_ff;
         end
         ramu_pkg::ST_M_N:   begin
            alu_req.op = ramu_pkg::ALU_MUL; alu_a = an_ff; alu_b = bn_ff;
         end
         ramu_pkg::ST_M_D:   begin
            alu_req.op = ramu_pkg::ALU_MUL; alu_a = ad_ff; alu_b = bd_ff;
         end
         ramu_pkg::ST_R_NUM: begin alu_a = rn_ff; alu_b = gx_ff; end
         ramu_pkg::ST_R_DEN: begin alu_a = rd_ff; alu_b = gx_ff; end
         default: ;
      endcase

      // Operation states issue once, then wait for done
      case (state_ff)
         ramu_pkg::ST_GCD, ramu_pkg::ST_A_Q1, ramu_pkg::ST_A_RD,
         ramu_pkg::ST_A_S1, ramu_pkg::ST_A_X, ramu_pkg::ST_A_S2,
         ramu_pkg::ST_A_Y, ramu_pkg::ST_M_N, ramu_pkg::ST_M_D,
         ramu_pkg::ST_R_NUM, ramu_pkg::ST_R_DEN: begin
            if (!pend_ff) begin
               alu_req.start = 1'b1;
               pend_in = 1'b1;
            end else if (alu_done) begin
               pend_in = 1'b0;
            end
         end
         default: ;
      endcase

      case (state_ff)
         ramu_pkg::ST_IDLE: begin
            if (req_valid) begin
               an_in  = req_a_num[WIDTH-1:0];
               ad_in  = req_a_den[WIDTH-1:0];
               bn_in  = req_b_num[WIDTH-1:0];
               bd_in  = req_b_den[WIDTH-1:0];
               ang_in = req_a_neg;
               bng_in = req_b_neg;
               pend_in = 1'b0;
               if (req_command == ramu_pkg::CMD_MUL) begin
                  state_in = ramu_pkg::ST_M_N;
               end else begin
                  gx_in    = req_a_den[WIDTH-1:0];
                  gy_in    = req_b_den[WIDTH-1:0];
                  ret_in   = ramu_pkg::ST_A_Q1;
                  state_in = ramu_pkg::ST_GCD;
               end
            end
         end
         // Euclid loop; the gcd is left in gx
         ramu_pkg::ST_GCD: begin
            if (gy_ff == '0) begin
               alu_req.start = 1'b0;
               pend_in  = 1'b0;
               state_in = ret_ff;
            end else if (pend_ff && alu_done) begin
               gx_in = gy_ff;
               gy_in = alu_rem;
            end
         end
         ramu_pkg::ST_A_Q1: if (pend_ff && alu_done) begin
            q_in = alu_res; state_in = ramu_pkg::ST_A_RD;
         end
         ramu_pkg::ST_A_RD: if (pend_ff && alu_done) begin
            rd_in = alu_res; state_in = ramu_pkg::ST_A_S1;
         end
         ramu_pkg::ST_A_S1: if (pend_ff && alu_done) begin
            q_in = alu_res; state_in = ramu_pkg::ST_A_X;
         end
         ramu_pkg::ST_A_X: if (pend_ff && alu_done) begin
            xv_in = alu_res; state_in = ramu_pkg::ST_A_S2;
         end
         ramu_pkg::ST_A_S2: if (pend_ff && alu_done) begin
            q_in = alu_res; state_in = ramu_pkg::ST_A_Y;
         end
         ramu_pkg::ST_A_Y: if (pend_ff && alu_done) begin
            yv_in = alu_res; state_in = ramu_pkg::ST_A_SUM;
         end
         // Signed combine of the scaled numerators
         ramu_pkg::ST_A_SUM: begin
            if (ang_ff == bng_ff) begin
               rn_in  = xv_ff + yv_ff;
               neg_in = ang_ff;
            end else if (xv_ff < yv_ff) begin
               rn_in  = yv_ff - xv_ff;
               neg_in = bng_ff;
            end else begin
               rn_in  = xv_ff - yv_ff;
               neg_in = ang_ff;
            end
            gx_in    = rn_in;
            gy_in    = rd_ff;
            ret_in   = ramu_pkg::ST_R_NUM;
            state_in = ramu_pkg::ST_GCD;
         end
         ramu_pkg::ST_M_N: if (pend_ff && alu_done) begin
            rn_in = alu_res; state_in = ramu_pkg::ST_M_D;
         end
         ramu_pkg::ST_M_D: if (pend_ff && alu_done) begin
            rd_in    = alu_res;
            neg_in   = ang_ff ^ bng_ff;
            gx_in    = rn_ff;
            gy_in    = alu_res;
            ret_in   = ramu_pkg::ST_R_NUM;
            state_in = ramu_pkg::ST_GCD;
         end
         // Reduction; skipped when the gcd is zero
         ramu_pkg::ST_R_NUM: begin
            if (gx_ff == '0) begin
               alu_req.start = 1'b0;
               pend_in  = 1'b0;
               state_in = ramu_pkg::ST_DONE;
            end else if (pend_ff && alu_done) begin
               rn_in = alu_res; state_in = ramu_pkg::ST_R_DEN;
            end
         end
         ramu_pkg::ST_R_DEN: if (pend_ff && alu_done) begin
            rd_in = alu_res; state_in = ramu_pkg::ST_DONE;
         end
         ramu_pkg::ST_DONE: if (!rsp_stall) state_in = ramu_pkg::ST_IDLE;
         default: state_in = ramu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ramu_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      ret_ff <= ret_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ang_ff <= ang_in; bng_ff <= bng_in; neg_ff <= neg_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      q_ff <= q_in; xv_ff <= xv_in; yv_ff <= yv_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
   end

   // Result item
   assign req_stall   = (state_ff != ramu_pkg::ST_IDLE);
   assign rsp_valid   = (state_ff == ramu_pkg::ST_DONE);
   assign rsp_res_num = ramu_pkg::PORT_W'(rn_ff);
   assign rsp_res_den = ramu_pkg::PORT_W'(rd_ff);
   assign rsp_res_neg = neg_ff;

endmodule

[sim/rational_checker.sv]
// Checker for the rational add/multiply unit: watches both channels,
// computes the reduced rational for each accepted item and compares.
// Depends on ramu_pkg for the command codes.
`timescale 1ns / 1ps

module rational_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_a_num,
   input  logic [63:0] req_a_den,
   input  logic        req_a_neg,
   input  logic [63:0] req_b_num,
   input  logic [63:0] req_b_den,
   input  logic        req_b_neg,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_res_num,
   input  logic [63:0] rsp_res_den,
   input  logic        rsp_res_neg,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct {
      logic [63:0] num;
      logic [63:0] den;
      logic        neg;
   } rational_type;

   rational_type reduced_q[$];

   function automatic logic [63:0] div_or_zero(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? 64'd0 : n / d;
   endfunction

   function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Reduced sum or product of the two operands
   function automatic rational_type rational_result(logic cmd,
         logic [63:0] an, logic [63:0] ad, logic an_neg,
         logic [63:0] bn, logic [63:0] bd, logic bn_neg);
      rational_type r;
      logic [63:0] x, y, g;
      if (cmd == ramu_pkg::CMD_MUL) begin
         r.num = an * bn;
         r.den = ad * bd;
         r.neg = an_neg ^ bn_neg;
      end else begin
         r.den = div_or_zero(ad, euclid_gcd(ad, bd)) * bd;
         x = div_or_zero(r.den, ad) * an;
         y = div_or_zero(r.den, bd) * bn;
         if (an_neg == bn_neg) begin
            r.num = x + y;
            r.neg = an_neg;
         end else if (x < y) begin
            r.num = y - x;
            r.neg = bn_neg;
         end else begin
            // equal magnitudes keep the first sign
            r.num = x - y;
            r.neg = an_neg;
         end
      end
      g = euclid_gcd(r.num, r.den);
      if (g != 0) begin
         r.num = r.num / g;
         r.den = r.den / g;
      end
      return r;
   endfunction

   // Predict on request, compare on response
   always @(posedge clock) begin
      rational_type e;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count    <= 0;
         result_count  <= 0;
         pending_count <= 0;
         reduced_q.delete();
      end else begin
         if (req_valid && !req_stall)
            reduced_q.push_back(rational_result(req_command, req_a_num, req_a_den,
               req_a_neg, req_b_num, req_b_den, req_b_neg));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (reduced_q.size() == 0) begin
               $error("unexpected result item");
               errs = errs + 1;
            end else begin
               e = reduced_q.pop_front();
               if (rsp_res_num !== e.num) begin
                  $error("res_num expected %0h actual %0h", e.num, rsp_res_num);
                  errs = errs + 1;
               end
               if (rsp_res_den !== e.den) begin
                  $error("res_den expected %0h actual %0h", e.den, rsp_res_den);
                  errs = errs + 1;
               end
               if (rsp_res_neg !== e.neg) begin
                  $error("res_neg expected %0b actual %0b", e.neg, rsp_res_neg);
                  errs = errs + 1;
               end
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= reduced_q.size();
      end
   end

endmodule

[sim/tb.sv]
// Testbench top for the rational add/multiply unit: clock, reset,
// stimulus and verdict. Depends on ramu_pkg, the unit and rational_checker.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_RANDOM = 1130;
   localparam int IDLE_LIMIT = 100000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = ramu_pkg::CMD_ADD;
   logic [63:0] req_a_num = 0, req_a_den = 1, req_b_num = 0, req_b_den = 1;
   logic        req_a_neg = 0, req_b_neg = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_res_num, rsp_res_den;
   logic        rsp_res_neg;
   int          fail_count, pending_count, result_count;
   int          idle_cycles = 0;
   bit          quiet_tail = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rational_add_multiply_unit dut (.*);
   rational_checker chk (.*);

   // Watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (!reset && idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Receiver stalls in short bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Wide values with sometimes small magnitudes so gcds are nontrivial
   function automatic logic [63:0] pick_value(bit nonzero);
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0:       v = rand64();
         1:       v = rand64() >> $urandom_range(0, 63);
         2:       v = 64'($urandom_range(0, 40));
         3:       v = 64'($urandom_range(1, 12)) * 64'($urandom_range(1, 720));
         4:       v = {$urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1}
                      << $urandom_range(0, 63);
         default: v = 64'($urandom_range(0, 1000));
      endcase
      if (nonzero && v == 0) v = 1;
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send(logic cmd, logic [63:0] an, logic [63:0] ad, logic a_neg,
                       logic [63:0] bn, logic [63:0] bd, logic b_neg);
      int n;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid   <= 1;
      req_command <= cmd;
      req_a_num   <= an;
      req_a_den   <= ad;
      req_a_neg   <= a_neg;
      req_b_num   <= bn;
      req_b_den   <= bd;
      req_b_neg   <= b_neg;
      while (req_stall) @(negedge clock);
      @(negedge clock);
   endtask

   localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, both commands, signed zeros, wrapping
      send(ramu_pkg::CMD_ADD, 1, 2, 0, 1, 3, 0);
      send(ramu_pkg::CMD_MUL, 2, 3, 1, 3, 4, 0);
      send(ramu_pkg::CMD_ADD, 3, 4, 0, 3, 4, 1);
      send(ramu_pkg::CMD_ADD, 3, 4, 1, 3, 4, 0);
      send(ramu_pkg::CMD_ADD, 0, 5, 1, 0, 7, 1);
      send(ramu_pkg::CMD_ADD, 0, 5, 0, 0, 7, 1);
      send(ramu_pkg::CMD_MUL, 0, 5, 1, 0, 7, 1);
      send(ramu_pkg::CMD_ADD, 1, 3, 0, 5, 6, 1);
      send(ramu_pkg::CMD_ADD, MAXV, MAXV, 0, MAXV, MAXV, 0);
      send(ramu_pkg::CMD_MUL, MAXV, MAXV, 1, MAXV, MAXV, 0);
      send(ramu_pkg::CMD_ADD, MAXV, 1, 0, MAXV, 1, 0);
      send(ramu_pkg::CMD_ADD, 1, MAXV, 0, 1, MAXV - 1, 1);
      send(ramu_pkg::CMD_MUL, MAXV, 1, 0, 2, 3, 1);
      send(ramu_pkg::CMD_ADD, 1, 64'h8000_0000_0000_0000, 1, 1, 3, 1);
      send(ramu_pkg::CMD_MUL, 64'h1_0000_0000, 1, 0, 64'h1_0000_0000, 1, 0);
      send(ramu_pkg::CMD_MUL, 0, 1, 0, 0, 1, 0);
      send(ramu_pkg::CMD_ADD, 0, 1, 0, 0, 1, 0);
      send(ramu_pkg::CMD_ADD, 7, 1, 1, 0, 1, 0);
      send(ramu_pkg::CMD_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0,
           64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1);

      // Hold off until every result is back
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);

      // Random items; final stretch without idling on either side
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM - 100) quiet_tail = 1;
         send(1'($urandom_range(0, 1)), pick_value(0), pick_value(1),
              1'($urandom_range(0, 1)), pick_value(0), pick_value(1),
              1'($urandom_range(0, 1)));
      end
      req_valid <= 0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("tb: covered %0d results of add and multiply, directed and random",
               result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
